/* src/adc_offset_calib_ema_conditioner_unit_macros.svh */
// assertion macros for the adc offset calibration conditioner
// used by the port checker
`ifndef ADC_OFFSET_CALIB_EMA_CONDITIONER_UNIT_MACROS_SVH
`define ADC_OFFSET_CALIB_EMA_CONDITIONER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define AOC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define AOC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* src/aoc_pkg.sv */
// package for the adc offset calibration conditioner
// constants, widths and the control state type; no dependencies
`timescale 1ns / 1ps
package aoc_pkg;
    localparam int CalibSamplesDef = 1000;
    localparam int AdcBitsDef      = 12;
    localparam int ChannelsDef     = 4;
    localparam int NCH             = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 24;
    localparam int IN_W            = 96;
    localparam int OUT_W           = 128;

    localparam logic [1:0] REG_ZERO   = 2'd0;
    localparam logic [1:0] REG_PALPHA = 2'd1;
    localparam logic [1:0] REG_CALPHA = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    localparam logic [15:0] ZERO_RST   = 16'd29782;
    localparam logic [23:0] PALPHA_RST = 24'd16777;
    localparam logic [23:0] CALPHA_RST = 24'd1678;
    localparam logic [15:0] PERIOD_RST = 16'd25000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POS,
        ST_CUR,
        ST_NEXT,
        ST_OUT
    } state_t;

    // serial multiplier request / response
    typedef struct packed {
        logic        start;
        logic [39:0] mcand;
        logic [23:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } mul_rsp_t;
endpackage

/* src/aoc_serial_mul.sv */
// bit-serial unsigned multiplier, one multiplier bit per cycle
// uses aoc_pkg
`timescale 1ns / 1ps
module aoc_serial_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  aoc_pkg::mul_req_t req,
    output aoc_pkg::mul_rsp_t rsp
);
    import aoc_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [63:0] mc_reg, mc_next;
    logic [23:0] mp_reg, mp_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            mc_next   = {24'd0, req.mcand};
            mp_next   = req.mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = {mc_reg[62:0], 1'b0};
            mp_next  = {1'b0, mp_reg[23:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule

/* src/aoc_serial_div.sv */
// restoring divider, one quotient bit per cycle, unsigned 40 by 32 bits
// uses aoc_pkg for nothing but style; quotient and remainder registered
`timescale 1ns / 1ps
module aoc_serial_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [39:0] quotient
);
    import aoc_pkg::*;

    logic [39:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[31:0], q_reg[39]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[39]};
                q_next = {q_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd39)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

/* src/adc_offset_calib_ema_conditioner_unit.sv */
// Offset calibration and EMA conditioning of four position and four current
// ADC channels. One sample set is taken at a time: per channel four serial
// multiplies for the two filters and one serial divide for the current,
// skipped when the denominator is not positive. The last calibration sample
// adds four serial divides for the offsets. The first CALIB_SAMPLES
// sets accumulate the current offset; calibrated then reads high. A result
// waits in the output register while the next set is already accepted.
`timescale 1ns / 1ps
module adc_offset_calib_ema_conditioner_unit #(
    parameter int CALIB_SAMPLES = aoc_pkg::CalibSamplesDef,
    parameter int ADC_BITS      = aoc_pkg::AdcBitsDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aoc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aoc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_code_a..d, cur_code_a..d, 12 bits each
    input  logic [aoc_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pos_smooth_a..d, cur_smooth_a..d
    output logic [aoc_pkg::OUT_W-1:0]     m_axis_tdata,
    // calibrated, telemetry_due
    output logic [1:0]                    m_axis_tuser
);
    import aoc_pkg::*;

    localparam int CodeShift = 16 - ADC_BITS;
    localparam int CntW      = $clog2(CALIB_SAMPLES + 1);

    logic [15:0] zero_reg;
    logic [23:0] palpha_reg, calpha_reg;
    logic [15:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg   <= ZERO_RST;
            palpha_reg <= PALPHA_RST;
            calpha_reg <= CALPHA_RST;
            period_reg <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ZERO:   zero_reg   <= cfg_data[15:0];
                REG_PALPHA: palpha_reg <= cfg_data;
                REG_CALPHA: calpha_reg <= cfg_data;
                REG_PERIOD: period_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [1:0]  ch_reg, ch_next;
    logic [1:0]  sub_reg, sub_next;
    logic        wait_reg, wait_next;
    logic [IN_W-1:0] in_reg, in_next;
    logic        in_full_reg, in_full_next;
    logic [27:0] acc_reg [NCH];
    logic [27:0] acc_next [NCH];
    logic [17:0] off_reg [NCH];
    logic [17:0] off_next [NCH];
    logic [35:0] pf_reg [NCH];
    logic [35:0] pf_next [NCH];
    logic [39:0] cf_reg [NCH];
    logic [39:0] cf_next [NCH];
    logic [CntW-1:0] cal_cnt_reg, cal_cnt_next;
    logic        cal_done_reg, cal_done_next;
    logic [15:0] tel_reg, tel_next;
    logic [63:0] t_reg, t_next;
    logic [16:0] q_reg, q_next;
    logic        neg_reg, neg_next;
    logic [OUT_W-1:0] res_reg, res_next;
    logic [OUT_W-1:0] od_reg, od_next;
    logic [1:0]  ou_reg, ou_next;
    logic        ov_reg, ov_next;
    logic        due_reg, due_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic        dstart, ddone;
    logic [39:0] ddividend, dquot;
    logic [31:0] ddivisor;

    aoc_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    aoc_serial_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddividend),
        .divisor(ddivisor), .done(ddone), .quotient(dquot)
    );

    logic [15:0] pcode, ccode;
    logic signed [18:0] num, den;
    logic [18:0] num_mag;
    logic [63:0] sum_t;
    logic [40:0] cur_sat;
    logic [27:0] amag;
    logic signed [29:0] s_acc;
    logic [16:0] co;
    logic [20:0] po;

    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        sub_next      = sub_reg;
        wait_next     = wait_reg;
        in_next       = in_reg;
        in_full_next  = in_full_reg;
        acc_next      = acc_reg;
        off_next      = off_reg;
        pf_next       = pf_reg;
        cf_next       = cf_reg;
        cal_cnt_next  = cal_cnt_reg;
        cal_done_next = cal_done_reg;
        tel_next      = tel_reg;
        t_next        = t_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        res_next      = res_reg;
        od_next       = od_reg;
        ou_next       = ou_reg;
        ov_next       = ov_reg;
        due_next      = due_reg;
        mreq          = '0;
        dstart        = 1'b0;
        ddividend     = '0;
        ddivisor      = '0;
        s_acc         = '0;
        amag          = '0;

        pcode   = 16'(in_reg[12*ch_reg +: 12]) << CodeShift;
        ccode   = 16'(in_reg[48 + 12*ch_reg +: 12]) << CodeShift;
        num     = 19'(ccode) - 19'(zero_reg)
                  - (cal_done_reg ? 19'(signed'(off_reg[ch_reg])) : 19'sd0);
        den     = 19'(zero_reg)
                  + (cal_done_reg ? 19'(signed'(off_reg[ch_reg])) : 19'sd0);
        num_mag = num[18] ? 19'(-num) : num;
        sum_t   = t_reg + mrsp.prod;
        cur_sat = neg_reg ? 41'(32768 - q_reg) : 41'(32768 + q_reg);
        po      = 21'((pf_reg[ch_reg] + 36'(1 << 19)) >> 20);
        co      = 17'(({1'b0, cf_reg[ch_reg]} + 41'(1 << 23)) >> 24);

        if (m_axis_tready && ov_reg)
            ov_next = 1'b0;
        if (s_axis_tvalid && !in_full_reg)
        begin
            in_next      = s_axis_tdata;
            in_full_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_full_reg)
                begin
                    if (!cal_done_reg && cal_cnt_reg < CntW'(CALIB_SAMPLES))
                    begin
                        for (int c = 0; c < NCH; c++)
                        begin
                            s_acc = 30'(signed'(acc_reg[c]))
                                    + 30'(16'(in_reg[48 + 12*c +: 12]) << CodeShift)
                                    - 30'(zero_reg);
                            if (s_acc > 30'sd134217727)
                                acc_next[c] = 28'h7ffffff;
                            else if (s_acc < -30'sd134217728)
                                acc_next[c] = 28'h8000000;
                            else
                                acc_next[c] = s_acc[27:0];
                        end
                        cal_cnt_next = cal_cnt_reg + CntW'(1);
                    end
                    ch_next   = '0;
                    wait_next = 1'b0;
                    if (!cal_done_reg
                        && cal_cnt_reg == CntW'(CALIB_SAMPLES - 1))
                        state_next = ST_DIV;
                    else
                        state_next = ST_POS;
                    sub_next = '0;
                end
            end
            ST_DIV:
            begin
                amag = acc_reg[ch_reg][27] ? 28'(-acc_reg[ch_reg]) : acc_reg[ch_reg];
                if (!wait_reg)
                begin
                    dstart    = 1'b1;
                    ddividend = 40'(amag) + 40'(CALIB_SAMPLES / 2);
                    ddivisor  = 32'(CALIB_SAMPLES);
                    wait_next = 1'b1;
                end
                else if (ddone)
                begin
                    off_next[ch_reg] = acc_reg[ch_reg][27] ? 18'(-dquot) : 18'(dquot);
                    wait_next = 1'b0;
                    ch_next   = ch_reg + 2'd1;
                    if (ch_reg == 2'(NCH - 1))
                    begin
                        cal_done_next = 1'b1;
                        state_next    = ST_POS;
                    end
                end
            end
            ST_POS:
            begin
                // sub 0: alpha*x, sub 1: (1-alpha)*f, then divide current
                if (!wait_reg)
                begin
                    mreq.start = 1'b1;
                    if (sub_reg == 2'd0)
                    begin
                        mreq.mcand  = 40'(pcode) << 20;
                        mreq.mplier = palpha_reg;
                    end
                    else
                    begin
                        mreq.mcand  = 40'(pf_reg[ch_reg]);
                        mreq.mplier = 24'(25'h1000000 - 25'(palpha_reg));
                    end
                    wait_next = 1'b1;
                    if (sub_reg == 2'd1 && palpha_reg == 24'd0)
                        mreq.mplier = 24'd0;
                end
                else if (mrsp.done)
                begin
                    wait_next = 1'b0;
                    if (sub_reg == 2'd0)
                    begin
                        t_next   = mrsp.prod + 64'(1 << 23);
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        // alpha zero: 2^24 factor handled as shift of f
                        if (palpha_reg == 24'd0)
                            pf_next[ch_reg] = pf_reg[ch_reg];
                        else
                            pf_next[ch_reg] = 36'(sum_t >> 24);
                        sub_next   = 2'd2;
                        state_next = ST_CUR;
                    end
                end
            end
            ST_CUR:
            begin
                if (sub_reg == 2'd2)
                begin
                    if (den[18] || den == 19'sd0)
                    begin
                        q_next   = num[18] ? 17'd32768 : (num == 19'sd0 ? 17'd0 : 17'd32767);
                        neg_next = num[18];
                        sub_next = 2'd0;
                    end
                    else if (!wait_reg)
                    begin
                        dstart    = 1'b1;
                        ddividend = (40'(num_mag) << 15) + 40'(den[18:1]);
                        ddivisor  = 32'(den);
                        wait_next = 1'b1;
                        neg_next  = num[18];
                    end
                    else if (ddone)
                    begin
                        wait_next = 1'b0;
                        sub_next  = 2'd0;
                        if (neg_reg)
                            q_next = (dquot > 40'd32768) ? 17'd32768 : 17'(dquot);
                        else
                            q_next = (dquot > 40'd32767) ? 17'd32767 : 17'(dquot);
                    end
                end
                else if (!wait_reg)
                begin
                    mreq.start = 1'b1;
                    if (sub_reg == 2'd0)
                    begin
                        mreq.mcand  = cur_sat[39:0] << 24;
                        mreq.mplier = calpha_reg;
                    end
                    else
                    begin
                        mreq.mcand  = cf_reg[ch_reg];
                        mreq.mplier = 24'(25'h1000000 - 25'(calpha_reg));
                    end
                    wait_next = 1'b1;
                end
                else if (mrsp.done)
                begin
                    wait_next = 1'b0;
                    if (sub_reg == 2'd0)
                    begin
                        t_next   = mrsp.prod + 64'(1 << 23);
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        if (calpha_reg != 24'd0)
                            cf_next[ch_reg] = 40'(sum_t >> 24);
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                res_next[16*ch_reg +: 16] = (po > 21'd65535) ? 16'hffff : po[15:0];
                res_next[64 + 16*ch_reg +: 16] =
                    ((co > 17'd65535) ? 16'hffff : co[15:0]) ^ 16'h8000;
                sub_next = '0;
                ch_next  = ch_reg + 2'd1;
                if (ch_reg == 2'(NCH - 1))
                    state_next = ST_OUT;
                else
                    state_next = ST_POS;
            end
            ST_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    od_next = res_reg;
                    if (32'(tel_reg) + 32'd1 >= 32'(period_reg))
                    begin
                        tel_next = '0;
                        due_next = 1'b1;
                    end
                    else
                    begin
                        tel_next = tel_reg + 16'd1;
                        due_next = 1'b0;
                    end
                    ou_next      = {due_next, cal_done_reg};
                    ov_next      = 1'b1;
                    in_full_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fresh filter states and control from reset; payload registers are not reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ch_reg       <= '0;
            sub_reg      <= '0;
            wait_reg     <= 1'b0;
            in_full_reg  <= 1'b0;
            cal_cnt_reg  <= '0;
            cal_done_reg <= 1'b0;
            tel_reg      <= '0;
            ov_reg       <= 1'b0;
            due_reg      <= 1'b0;
            for (int c = 0; c < NCH; c++)
            begin
                acc_reg[c] <= '0;
                off_reg[c] <= '0;
                pf_reg[c]  <= '0;
                cf_reg[c]  <= 40'h8000000000;
            end
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            sub_reg      <= sub_next;
            wait_reg     <= wait_next;
            in_full_reg  <= in_full_next;
            cal_cnt_reg  <= cal_cnt_next;
            cal_done_reg <= cal_done_next;
            tel_reg      <= tel_next;
            ov_reg       <= ov_next;
            due_reg      <= due_next;
            acc_reg      <= acc_next;
            off_reg      <= off_next;
            pf_reg       <= pf_next;
            cf_reg       <= cf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        t_reg   <= t_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        od_reg  <= od_next;
        ou_reg  <= ou_next;
    end

    assign s_axis_tready = !in_full_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
endmodule

/* src/aoc_checker.sv */
// port-level checker for the conditioner, bound to the top level
// uses the macros header
`timescale 1ns / 1ps
`include "adc_offset_calib_ema_conditioner_unit_macros.svh"
module aoc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [1:0]   m_axis_tuser
);
    // a result showing calibrated is followed by no result or one that shows it too
    `AOC_ASSERT_NEXT(a_cal_sticky, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], !m_axis_tvalid || m_axis_tuser[0])
    // a stalled result keeps valid asserted
    `AOC_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // an accepted item blocks input until its result is formed
    `AOC_ASSERT_NEXT(a_one, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind adc_offset_calib_ema_conditioner_unit aoc_checker u_aoc_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser)
);

/* verif/tb_adc_offset_calib_ema_conditioner_unit.sv */
// testbench for the adc offset calibration and ema conditioner
// self-checking against a behavioral predictor; depends on aoc_pkg and the unit
`timescale 1ns / 1ps
module tb_adc_offset_calib_ema_conditioner_unit;
    import aoc_pkg::*;

    localparam int CalSamples = 1000;
    localparam longint OneQ24 = 64'd16777216;
    localparam longint HalfQ24 = 64'd8388608;
    localparam longint CurBias = 64'd549755813888;
    localparam int Latency = 1000;
    localparam longint CycleLimit = 64'd8000000;

    typedef struct packed {
        logic [3:0][15:0] cur;
        logic [3:0][15:0] pos;
    } smooth_t;

    typedef struct {
        smooth_t data;
        logic    calibrated;
        logic    due;
    } sample_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    adc_offset_calib_ema_conditioner_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    // predictor state
    longint zero_code, pos_alpha, cur_alpha, tele_period;
    longint offset_sum [4];
    longint offset_val [4];
    longint cal_count;
    bit     cal_done;
    longint pos_state [4];
    longint cur_state [4];
    longint tele_count;

    sample_out_t expected_samples [$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int due_seen = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;
    bit burst_mode = 1'b1;

    // unsigned math, the weighted sum of the current filter needs all 64 bits
    function automatic longint ema_step(longint f, longint x, longint alpha);
        longint unsigned a, fu, xu;
        a = alpha & 64'hFFFFFF;
        fu = f;
        xu = x;
        return longint'((a * xu + (OneQ24 - a) * fu + HalfQ24) >> 24);
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint current_q15(longint code16, longint offs);
        longint num, den, q;
        num = code16 - zero_code - offs;
        den = zero_code + offs;
        if (den <= 0)
            return num > 0 ? 32767 : (num < 0 ? -32768 : 0);
        q = round_div(num * 32768, den);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function automatic sample_out_t condition_sample(logic [IN_W-1:0] raw);
        sample_out_t r;
        longint cur16 [4];
        longint s, p16, q, po, cb, co, cnt;
        for (int c = 0; c < 4; c++)
            cur16[c] = longint'(raw[48 + 12*c +: 12]) << 4;
        if (!cal_done && cal_count < CalSamples) begin
            for (int c = 0; c < 4; c++) begin
                s = offset_sum[c] + cur16[c] - zero_code;
                if (s > 134217727) s = 134217727;
                if (s < -134217728) s = -134217728;
                offset_sum[c] = s;
            end
            cal_count++;
            if (cal_count >= CalSamples) begin
                for (int c = 0; c < 4; c++)
                    offset_val[c] = round_div(offset_sum[c], CalSamples);
                cal_done = 1'b1;
            end
        end
        for (int c = 0; c < 4; c++) begin
            p16 = longint'(raw[12*c +: 12]) << 4;
            q = current_q15(cur16[c], cal_done ? offset_val[c] : 0);
            pos_state[c] = ema_step(pos_state[c], p16 << 20, pos_alpha);
            po = (pos_state[c] + (64'd1 << 19)) >>> 20;
            if (po > 65535) po = 65535;
            r.data.pos[c] = po[15:0];
            cb = ema_step(cur_state[c] + CurBias, (q + 32768) * OneQ24, cur_alpha);
            cur_state[c] = cb - CurBias;
            co = (cb + HalfQ24) >>> 24;
            if (co > 65535) co = 65535;
            r.data.cur[c] = co[15:0] - 16'd32768;
        end
        cnt = tele_count + 1;
        r.due = cnt >= tele_period;
        tele_count = r.due ? 0 : (cnt & 64'hFFFF);
        r.calibrated = cal_done;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t timeout", $time);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            case (cycles[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) != 0);
            endcase
    end

    // result checker
    always @(posedge clk)
    begin
        sample_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser[1]) due_seen++;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer %h", $time, m_axis_tdata);
            end else begin
                want = expected_samples.pop_front();
                for (int c = 0; c < 4; c++) begin
                    if (m_axis_tdata[16*c +: 16] !== want.data.pos[c]) begin
                        errors++;
                        $display("%0t pos ch%0d exp %h got %h", $time, c,
                                 want.data.pos[c], m_axis_tdata[16*c +: 16]);
                    end
                    if (m_axis_tdata[64 + 16*c +: 16] !== want.data.cur[c]) begin
                        errors++;
                        $display("%0t cur ch%0d exp %h got %h", $time, c,
                                 want.data.cur[c], m_axis_tdata[64 + 16*c +: 16]);
                    end
                end
                if (m_axis_tuser[0] !== want.calibrated) begin
                    errors++;
                    $display("%0t calibrated exp %b got %b", $time,
                             want.calibrated, m_axis_tuser[0]);
                end
                if (m_axis_tuser[1] !== want.due) begin
                    errors++;
                    $display("%0t telemetry_due exp %b got %b", $time,
                             want.due, m_axis_tuser[1]);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ZERO:   zero_code = longint'(val[15:0]);
            REG_PALPHA: pos_alpha = longint'(val);
            REG_CALPHA: cur_alpha = longint'(val);
            default:    tele_period = longint'(val[15:0]);
        endcase
    endtask

    // valid stays up between items of a burst and drops for a gap
    task automatic send_sample(logic [IN_W-1:0] raw);
        int gap;
        if (burst_mode && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= raw;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_samples.push_back(condition_sample(raw));
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (Latency) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_sample(int lo, int hi);
        logic [IN_W-1:0] raw;
        for (int k = 0; k < 8; k++)
            raw[12*k +: 12] = 12'($urandom_range(lo, hi));
        return raw;
    endfunction

    // extremes of the codes, while calibration is summing
    task automatic test_code_extremes();
        send_sample('0);
        send_sample({IN_W{1'b1}});
        send_sample({48'hFFF000FFF000, 48'h000FFF000FFF});
        send_sample({48'h555AAA555AAA, 48'hAAA555AAA555});
        for (int k = 0; k < 8; k++)
            send_sample(rand_sample(0, 4095));
    endtask

    // run through the rest of calibration with codes near the zero level
    task automatic test_calibration();
        while (items_sent < CalSamples + 4)
            send_sample(rand_sample(1800, 1925));
    endtask

    // hold the receiver off so the block backs up
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (4000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 6; k++) send_sample(rand_sample(0, 4095));
                s_axis_tvalid <= 1'b0;
            end
        join
        drain();
    endtask

    // extreme settings: zero code, alpha and period each at its limits
    task automatic test_extreme_settings();
        write_reg(REG_ZERO, 24'd0);
        write_reg(REG_PALPHA, 24'hFFFFFF);
        write_reg(REG_CALPHA, 24'hFFFFFF);
        write_reg(REG_PERIOD, 24'd1);
        send_sample('0);
        send_sample({IN_W{1'b1}});
        for (int k = 0; k < 6; k++) send_sample(rand_sample(0, 4095));
        drain();
        write_reg(REG_ZERO, 24'hFFFF);
        write_reg(REG_PALPHA, 24'd1);
        write_reg(REG_CALPHA, 24'd1);
        write_reg(REG_PERIOD, 24'hFFFF);
        send_sample({IN_W{1'b1}});
        send_sample('0);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_ZERO, 24'($urandom_range(0, 65535)));
            write_reg(REG_PALPHA, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(REG_CALPHA, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(REG_PERIOD, 24'($urandom_range(1, 40)));
            burst_mode = (ph % 3) != 0;
            for (int k = 0; k < 100; k++) send_sample(rand_sample(0, 4095));
            drain();
        end
        burst_mode = 1'b1;
    endtask

    initial
    begin
        zero_code = ZERO_RST;
        pos_alpha = PALPHA_RST;
        cur_alpha = CALPHA_RST;
        tele_period = PERIOD_RST;
        for (int c = 0; c < 4; c++)
        begin
            offset_sum[c] = 0;
            offset_val[c] = 0;
            pos_state[c] = 0;
            cur_state[c] = 0;
        end
        cal_count = 0;
        cal_done = 1'b0;
        tele_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_PERIOD, 24'd7);
        test_code_extremes();
        test_calibration();
        test_backpressure();
        test_extreme_settings();
        test_random_settings();
        drain();
        $display("covered %0d samples through calibration and %0d checked results,",
                 items_sent, results_seen);
        $display("with %0d telemetry pulses over extreme and random settings", due_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/aoc_pkg.sv
src/aoc_serial_mul.sv
src/aoc_serial_div.sv
src/adc_offset_calib_ema_conditioner_unit.sv
src/aoc_checker.sv
verif/tb_adc_offset_calib_ema_conditioner_unit.sv
